/* sv/lfo_modulated_delay_and_tremolo_unit_defines.svh */
// Assertion macros for the LFO modulated delay and tremolo unit.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LFO_MODULATED_DELAY_AND_TREMOLO_UNIT_DEFINES_SVH
`define LFO_MODULATED_DELAY_AND_TREMOLO_UNIT_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define LFOMDT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfomdt property failed");

// Property checked on every rising edge, reset included.
`define LFOMDT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("lfomdt property failed around reset");

`endif

/* sv/lfomdt_pkg.sv */
// Shared types, constants and the sine table builder of the LFO delay unit.
// No dependencies; every other file but the assertion macro header imports this package.
package lfomdt_pkg;

  localparam int RING_DEPTH   = 2048;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);
  // Queue entries plus the item in the back end plus the output register.
  localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;

  localparam int SAMPLE_W = 24;
  localparam int RATE_W   = 16;
  localparam int STEP_W   = 15;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-3:0] REG_RATE   = '0;
  localparam logic [RATE_W-1:0]  RATE_RESET = 16'hFFFF;

  localparam logic [30:0] BASE_ONE       = 31'd2052421705;
  localparam logic [30:0] BASE_TWO       = 31'd1172812403;
  localparam int          BASE_DELAY     = 1132;
  localparam logic [30:0] MOD_OFFSET_Q30 = 31'd1215478628;
  localparam logic [20:0] MOD_SLOPE_Q15  = 21'd1836122;
  localparam logic signed [15:0] MIX_GAIN_Q15 = 16'sd13107;
  localparam logic [13:0] TREM_GAIN_Q15  = 14'd16220;
  localparam int          ROUND_HALF_Q15 = 16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [15:0] sine_t;
  typedef sine_t sine_tab_t [SINE_ENTRIES];

  typedef struct packed {
    sample_t left;
    sample_t right;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t item;
  } qhead_t;

  // Quarter-wave fold and a truncating Horner series up to x^11, rounded to Q1.15.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint unsigned   p, a, x, x2, t, s;
    longint            f;
    bit                neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      p = (64'(k) << 32) / SINE_ENTRIES;
      if (p < 64'h4000_0000) f = longint'(p);
      else if (p < 64'hC000_0000) f = 64'sh8000_0000 - longint'(p);
      else f = longint'(p) - 64'sh1_0000_0000;
      neg = (f < 0);
      a   = neg ? longint'(-f) : longint'(f);
      x   = (a * 64'd6746518852) >> 32;
      x2  = (x * x) >> 30;
      t   = 64'd1073741824 - x2 / 110;
      t   = 64'd1073741824 - ((x2 * t) >> 30) / 72;
      t   = 64'd1073741824 - ((x2 * t) >> 30) / 42;
      t   = 64'd1073741824 - ((x2 * t) >> 30) / 20;
      t   = 64'd1073741824 - ((x2 * t) >> 30) / 6;
      s   = (x * t) >> 30;
      s   = (s + 64'd16384) >> 15;
      if (s > 64'd32767) s = 64'd32767;
      tab[k] = neg ? -sine_t'(s[15:0]) : sine_t'(s[15:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* sv/lfomdt_if.sv */
// Stream interfaces for the stereo sample items entering and leaving the unit.
// Depends on lfomdt_pkg for the sample type.
interface lfomdt_in_if;
  import lfomdt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;
  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface lfomdt_out_if;
  import lfomdt_pkg::*;
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

/* sv/lfomdt_front.sv */
// Front end: takes items from the input channel into a short queue.
// Depends on lfomdt_pkg and lfomdt_in_if.
module lfomdt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfomdt_in_if.sink          in_ch,
  input  logic               pop_i,
  output lfomdt_pkg::qhead_t head_o
);
  import lfomdt_pkg::*;

  qentry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]   count_q, count_d;
  logic                  push, pop;

  assign in_ch.ready = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{left: in_ch.left_in, right: in_ch.right_in};
    end
  end

endmodule

/* sv/lfomdt_back.sv */
// Back end: LFO phases, sine lookups, delay ring, mixing and the output register.
// Depends on lfomdt_pkg and lfomdt_out_if.
module lfomdt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lfomdt_pkg::RATE_W-1:0] rate_i,
  input  lfomdt_pkg::qhead_t            head_i,
  output logic                          pop_o,
  lfomdt_out_if.source                  out_ch
);
  import lfomdt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INDEX = 7'b0000010,
    ST_SINE  = 7'b0000100,
    ST_DELAY = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_MULT  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [31:0]          phase1_q, phase1_d, phase2_q, phase2_d;
  logic [RING_AW-1:0]   wp_q, wp_d;
  logic                 wrapped_q, wrapped_d;
  logic                 out_valid_q, out_valid_d;

  logic [STEP_W-1:0]    step1_q, step2_q;
  sample_t              l_q, r_q, dly_q, out_left_q, out_right_q;
  logic [SINE_AW-1:0]   idx1_q, idx2_q;
  sine_t                s1_q, s2_q;
  logic [RING_AW-1:0]   dist_q;
  logic [15:0]          g_q;
  logic                 dly_ok_q;
  logic signed [40:0]   lprod_q, rprod_q;
  logic [SAMPLE_W-1:0]  ring_mem [RING_DEPTH];

  logic                 pop, load;
  logic [46:0]          sp1_w, sp2_w;
  logic [63:0]          ip1_w, ip2_w;
  logic [37:0]          dp_w;
  logic [16:0]          tv_w;
  logic [30:0]          gp_w;
  logic [RING_AW:0]     rsum_w;
  logic [RING_AW-1:0]   rd_w;
  sample_t              dly_sel_w;
  logic signed [24:0]   lsum_w;
  logic signed [40:0]   lrnd_w, rrnd_w;

  function automatic sample_t sat24(logic signed [40:0] v);
    sample_t res;
    if (v > 41'sd8388607) res = 24'sh7FFFFF;
    else if (v < -41'sd8388608) res = 24'sh800000;
    else res = v[SAMPLE_W-1:0];
    return res;
  endfunction

  assign pop   = (state_q == ST_IDLE) && head_i.valid;
  assign pop_o = pop;
  assign load  = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

  // Phase steps follow the rate register; the user must change it only while the unit is idle, unenforced here.
  assign sp1_w = 47'(rate_i) * 47'(BASE_ONE);
  assign sp2_w = 47'(rate_i) * 47'(BASE_TWO);

  assign ip1_w = 64'(phase1_q) * 64'(SINE_ENTRIES);
  assign ip2_w = 64'(phase2_q) * 64'(SINE_ENTRIES);

  // Delay length from the first sine, offset so that s1 + 32768 is unsigned.
  assign dp_w = 38'(MOD_OFFSET_Q30) + 38'(MOD_SLOPE_Q15) * 38'({~s1_q[15], s1_q[14:0]});
  // Tremolo gain from the second sine: 32768 - s2 is always positive.
  assign tv_w = 17'h08000 - {s2_q[15], s2_q};
  assign gp_w = 31'(TREM_GAIN_Q15) * 31'(tv_w) + 31'(ROUND_HALF_Q15);

  assign rsum_w = (RING_AW + 1)'(wp_q) + (RING_AW + 1)'(RING_DEPTH) - (RING_AW + 1)'(dist_q);
  assign rd_w   = (rsum_w >= (RING_AW + 1)'(RING_DEPTH))
                  ? RING_AW'(rsum_w - (RING_AW + 1)'(RING_DEPTH)) : RING_AW'(rsum_w);

  // Entries not yet written since reset read as silence.
  assign dly_sel_w = dly_ok_q ? dly_q : '0;
  assign lsum_w    = 25'(l_q) + 25'(dly_sel_w);

  assign lrnd_w = (lprod_q + 41'(ROUND_HALF_Q15)) >>> 15;
  assign rrnd_w = (rprod_q + 41'(ROUND_HALF_Q15)) >>> 15;

  always_comb begin
    state_d     = state_q;
    phase1_d    = phase1_q;
    phase2_d    = phase2_q;
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    out_valid_d = out_valid_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          phase1_d = phase1_q + 32'(step1_q);
          phase2_d = phase2_q + 32'(step2_q);
          state_d  = ST_INDEX;
        end
      end
      ST_INDEX: state_d = ST_SINE;
      ST_SINE:  state_d = ST_DELAY;
      ST_DELAY: state_d = ST_READ;
      ST_READ:  state_d = ST_MULT;
      ST_MULT:  state_d = ST_OUT;
      ST_OUT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (wp_q == RING_AW'(RING_DEPTH - 1)) begin
            wp_d      = '0;
            wrapped_d = 1'b1;
          end else begin
            wp_d = wp_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase1_q    <= '0;
      phase2_q    <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase1_q    <= phase1_d;
      phase2_q    <= phase2_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step1_q <= sp1_w[46:32];
    step2_q <= sp2_w[46:32];
    if (pop) begin
      l_q <= head_i.item.left;
      r_q <= head_i.item.right;
    end
    if (state_q == ST_INDEX) begin
      idx1_q <= ip1_w[32 +: SINE_AW];
      idx2_q <= ip2_w[32 +: SINE_AW];
    end
    if (state_q == ST_SINE) begin
      s1_q <= SINE_TAB[idx1_q];
      s2_q <= SINE_TAB[idx2_q];
    end
    if (state_q == ST_DELAY) begin
      dist_q <= RING_AW'(BASE_DELAY) + RING_AW'(dp_w[37:30]);
      g_q    <= gp_w[30:15];
    end
    if (state_q == ST_READ) begin
      dly_ok_q <= wrapped_q || (wp_q >= dist_q);
    end
    if (state_q == ST_MULT) begin
      lprod_q <= 41'(lsum_w) * 41'(MIX_GAIN_Q15);
      rprod_q <= 41'(r_q) * 41'($signed({1'b0, g_q}));
    end
    if (load) begin
      out_left_q  <= sat24(lrnd_w);
      out_right_q <= sat24(rrnd_w);
    end
  end

  // Delay ring: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      ring_mem[wp_q] <= head_i.item.left;
    end
    if (state_q == ST_READ) begin
      dly_q <= ring_mem[rd_w];
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.left_out  = out_left_q;
  assign out_ch.right_out = out_right_q;

endmodule

/* sv/lfo_modulated_delay_and_tremolo_unit.sv */
// Top level of the LFO modulated delay and tremolo unit: register port and wiring.
// Depends on lfomdt_pkg, lfomdt_if, lfomdt_front and lfomdt_back.
//
// Each item is one stereo pair of Q1.23 samples and yields exactly one result pair.
// The left sample goes through a 2048-entry delay ring whose tap moves between
// 1133 and 1245 samples back under a slow sine LFO; the output is 0.4 times the
// sum of the dry and delayed samples. The right sample is scaled by a tremolo gain
// driven by a second, slower LFO. Both LFOs run at their base rates (0.35 Hz and
// 0.2 Hz at 48 kHz) scaled by the 16-bit rate register at byte address 0, which
// resets to 0xFFFF. Once an item leaves the input queue, the back end sequencer
// steps it through the phase add, the table index multiply, the sine table read,
// the delay and gain multiplies, the ring read, the mix multiplies and the
// rounding in turn, and takes no new item until the result is in the output
// register. A two item queue in front and a result register behind let either
// side stall without stopping the other. The delay ring is not swept after
// reset: a wrap flag marks when every entry has been written, and taps that land
// on entries not yet written read as zero, so items are accepted straight after
// reset.
module lfo_modulated_delay_and_tremolo_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lfomdt_in_if.sink                          in_ch,
  lfomdt_out_if.source                       out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfomdt_pkg::PADDR_W-1:0]     paddr,
  input  logic [lfomdt_pkg::PDATA_W-1:0]     pwdata,
  output logic [lfomdt_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready
);
  import lfomdt_pkg::*;

  logic [RATE_W-1:0] rate_q;
  logic              rate_sel;
  qhead_t            head;
  logic              pop;

  // The upper address bits pick the word; the lower two are ignored.
  assign rate_sel = (paddr[PADDR_W-1:2] == REG_RATE);
  assign pready   = 1'b1;
  assign prdata   = rate_sel ? PDATA_W'(rate_q) : '0;

  // Writes land on the access cycle; only the low half of the data is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (psel && penable && pwrite && rate_sel) begin
      rate_q <= pwdata[RATE_W-1:0];
    end
  end

  lfomdt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .pop_i  (pop),
    .head_o (head)
  );

  lfomdt_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rate_i (rate_q),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

/* sv/lfomdt_checker.sv */
// Port-level checks for the LFO modulated delay and tremolo unit, with its bind.
// Depends on lfomdt_pkg and the assertion macro header.
`include "lfo_modulated_delay_and_tremolo_unit_defines.svh"

module lfomdt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input lfomdt_pkg::sample_t        left_out,
  input lfomdt_pkg::sample_t        right_out
);
  import lfomdt_pkg::*;

  localparam int PEND_W = $clog2(MAX_INFLIGHT + 1) + 1;

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_q;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // An edge seen with reset low leaves the unit empty and ready at the next edge.
  `LFOMDT_ASSERT_RST(a_reset_state, !rst_ni |=> in_ready && !out_valid)
  `LFOMDT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
  `LFOMDT_ASSERT(a_no_invented, out_acc |-> pend_q != '0)
  `LFOMDT_ASSERT(a_inflight_bound, pend_q <= PEND_W'(MAX_INFLIGHT))

endmodule

bind lfo_modulated_delay_and_tremolo_unit lfomdt_checker u_lfomdt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .left_out  (out_ch.left_out),
  .right_out (out_ch.right_out)
);
